// ===== rtl/core/sd_spi_init_sequencer_macros.svh =====
// assertion macros shared by the sd spi init sequencer rtl
// no dependencies; pulled in by the top level only
`ifndef SD_SPI_INIT_SEQUENCER_MACROS_SVH
`define SD_SPI_INIT_SEQUENCER_MACROS_SVH

// same-cycle implication, checked while reset is low
`define SDSPI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked while reset is low
`define SDSPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sdspi_pkg.sv =====
// types and constants of the sd spi init sequencer
// no dependencies; used by every module of the block
package sdspi_pkg;

   // input transaction modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_RESP  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [1:0] CSR_IF_COND_ARG   = 2'd1;
   localparam logic [1:0] CSR_OP_COND_ARG   = 2'd2;

   // csr reset values
   localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd1000;
   localparam logic [11:0] IF_COND_ARG_RST   = 12'h1AA;
   localparam logic [31:0] OP_COND_ARG_RST   = 32'h4000_0000;

   // command indexes
   localparam logic [7:0] CMD_GO_IDLE   = 8'd0;
   localparam logic [7:0] CMD_IF_COND   = 8'd8;
   localparam logic [7:0] CMD_READ_OCR  = 8'd58;
   localparam logic [7:0] CMD_APP_CMD   = 8'd55;
   localparam logic [7:0] CMD_OP_COND   = 8'd41;
   localparam logic [7:0] CMD_START_BIT = 8'h40;

   // frame crc bytes
   localparam logic [7:0] CRC_CMD0    = 8'h95;
   localparam logic [7:0] CRC_CMD8    = 8'h87;
   localparam logic [7:0] CRC_DEFAULT = 8'h01;
   localparam logic [7:0] CRC_STOP    = 8'h01;

   // card kinds
   localparam logic [1:0] KIND_V1     = 2'd0;
   localparam logic [1:0] KIND_V2_SC  = 2'd1;
   localparam logic [1:0] KIND_V2_HC  = 2'd2;
   localparam logic [1:0] KIND_FAILED = 2'd3;

   // failure causes
   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_POWER_ON = 3'd1;
   localparam logic [2:0] CAUSE_ECHO     = 3'd2;
   localparam logic [2:0] CAUSE_VOLTAGE  = 3'd3;
   localparam logic [2:0] CAUSE_NOT_SD   = 3'd4;
   localparam logic [2:0] CAUSE_OCR      = 3'd5;
   localparam logic [2:0] CAUSE_OP_COND  = 3'd6;
   localparam logic [2:0] CAUSE_TIMEOUT  = 3'd7;

   localparam logic [19:0] TICK_MAX = 20'hF_FFFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  r1;
      logic [31:0] tail;
   } req_item_type;

   typedef struct packed {
      logic        issue_command;
      logic [7:0]  cmd_byte;
      logic [31:0] argument;
      logic [7:0]  crc_byte;
      logic        done_res;
      logic [1:0]  card_kind;
      logic [2:0]  fail_cause;
   } rsp_item_type;

   typedef struct packed {
      logic [19:0] timeout_ticks;
      logic [11:0] if_cond_arg;
      logic [31:0] op_cond_arg;
   } cfg_type;

   // command frame result
   function automatic rsp_item_type cmd_frame(input logic [7:0] idx,
                                              input logic [31:0] arg,
                                              input logic [7:0] crc);
      rsp_item_type r;
      r               = '0;
      r.issue_command = 1'b1;
      r.cmd_byte      = idx | CMD_START_BIT;
      r.argument      = arg;
      r.crc_byte      = crc | CRC_STOP;
      return r;
   endfunction

   // end-of-sequence result
   function automatic rsp_item_type done_frame(input logic [1:0] kind,
                                               input logic [2:0] cause);
      rsp_item_type r;
      r            = '0;
      r.done_res   = 1'b1;
      r.card_kind  = kind;
      r.fail_cause = cause;
      return r;
   endfunction

endpackage

// ===== rtl/core/sdspi_csr.sv =====
// configuration registers of the sd spi init sequencer
// depends on sdspi_pkg
module sdspi_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output sdspi_pkg::cfg_type   cfg
);
   import sdspi_pkg::*;

   cfg_type cfg_ff;

   // register write, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
         cfg_ff.if_cond_arg   <= IF_COND_ARG_RST;
         cfg_ff.op_cond_arg   <= OP_COND_ARG_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata[19:0];
            CSR_IF_COND_ARG:   cfg_ff.if_cond_arg   <= csr_wdata[11:0];
            CSR_OP_COND_ARG:   cfg_ff.op_cond_arg   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/sdspi_fsm.sv =====
// sequencing state and per-transaction decision logic
// depends on sdspi_pkg
module sdspi_fsm (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  sdspi_pkg::req_item_type  item,
   input  sdspi_pkg::cfg_type       cfg,
   output logic                     has_result,
   output sdspi_pkg::rsp_item_type  result
);
   import sdspi_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_CMD0   = 3'd1;
   localparam logic [2:0] PH_CMD8   = 3'd2;
   localparam logic [2:0] PH_OCR1   = 3'd3;
   localparam logic [2:0] PH_CMD55  = 3'd4;
   localparam logic [2:0] PH_ACMD41 = 3'd5;
   localparam logic [2:0] PH_OCR2   = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   logic        version_two_ff, version_two_in;
   logic        first_op_ff, first_op_in;
   logic [19:0] tick_count_ff, tick_count_in;
   logic        timeout_ff, timeout_in;

   logic        illegal, idle, r1_error;
   logic [19:0] tick_inc;

   assign illegal  = item.r1[2];
   assign idle     = item.r1[0];
   assign r1_error = |item.r1[7:1];
   assign tick_inc = (tick_count_ff < TICK_MAX) ? tick_count_ff + 20'd1 : tick_count_ff;

   // next state and result
   always_comb begin
      phase_in       = phase_ff;
      version_two_in = version_two_ff;
      first_op_in    = first_op_ff;
      tick_count_in  = tick_count_ff;
      timeout_in     = timeout_ff;
      has_result     = 1'b0;
      result         = '0;
      unique case (item.mode)
         MODE_START: begin
            version_two_in = 1'b1;
            first_op_in    = 1'b1;
            tick_count_in  = '0;
            timeout_in     = 1'b0;
            phase_in       = PH_CMD0;
            has_result     = 1'b1;
            result         = cmd_frame(CMD_GO_IDLE, '0, CRC_CMD0);
         end
         MODE_TICK: begin
            if (phase_ff inside {PH_CMD55, PH_ACMD41}) begin
               tick_count_in = tick_inc;
               if (tick_inc >= cfg.timeout_ticks) begin
                  timeout_in = 1'b1;
               end
            end
         end
         MODE_RESP: begin
            unique case (phase_ff) inside
               PH_CMD0: begin
                  has_result = 1'b1;
                  if (r1_error) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED, CAUSE_POWER_ON);
                  end else begin
                     phase_in = PH_CMD8;
                     result   = cmd_frame(CMD_IF_COND, {20'd0, cfg.if_cond_arg}, CRC_CMD8);
                  end
               end
               PH_CMD8: begin
                  has_result = 1'b1;
                  if (!illegal && item.tail[7:0] != cfg.if_cond_arg[7:0]) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED, CAUSE_ECHO);
                  end else if (!illegal && item.tail[11:8] != cfg.if_cond_arg[11:8]) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED, CAUSE_VOLTAGE);
                  end else begin
                     if (illegal) begin
                        version_two_in = 1'b0;
                     end
                     phase_in = PH_OCR1;
                     result   = cmd_frame(CMD_READ_OCR, '0, CRC_DEFAULT);
                  end
               end
               PH_OCR1: begin
                  has_result = 1'b1;
                  if (illegal) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED, CAUSE_NOT_SD);
                  end else if (r1_error) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED, CAUSE_OCR);
                  end else begin
                     tick_count_in = '0;
                     timeout_in    = 1'b0;
                     first_op_in   = 1'b1;
                     phase_in      = PH_CMD55;
                     result        = cmd_frame(CMD_APP_CMD, '0, CRC_DEFAULT);
                  end
               end
               PH_CMD55: begin
                  has_result = 1'b1;
                  if (r1_error) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED,
                                           (first_op_ff && illegal) ? CAUSE_NOT_SD
                                                                    : CAUSE_OP_COND);
                  end else begin
                     phase_in = PH_ACMD41;
                     result   = cmd_frame(CMD_OP_COND, cfg.op_cond_arg, CRC_DEFAULT);
                  end
               end
               PH_ACMD41: begin
                  has_result = 1'b1;
                  if (first_op_ff && illegal) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED, CAUSE_NOT_SD);
                  end else if (r1_error) begin
                     phase_in = PH_DONE;
                     result   = done_frame(KIND_FAILED, CAUSE_OP_COND);
                  end else if (!idle) begin
                     phase_in = PH_OCR2;
                     result   = cmd_frame(CMD_READ_OCR, '0, CRC_DEFAULT);
                  end else begin
                     first_op_in = 1'b0;
                     if (timeout_ff) begin
                        phase_in = PH_DONE;
                        result   = done_frame(KIND_FAILED, CAUSE_TIMEOUT);
                     end else begin
                        phase_in = PH_CMD55;
                        result   = cmd_frame(CMD_APP_CMD, '0, CRC_DEFAULT);
                     end
                  end
               end
               PH_OCR2: begin
                  has_result = 1'b1;
                  phase_in   = PH_DONE;
                  if (|item.r1) begin
                     result = done_frame(KIND_FAILED, CAUSE_OCR);
                  end else if (!version_two_ff) begin
                     result = done_frame(KIND_V1, CAUSE_NONE);
                  end else begin
                     result = done_frame(item.tail[30] ? KIND_V2_HC : KIND_V2_SC, CAUSE_NONE);
                  end
               end
               PH_IDLE, PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // state registers, updated once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         version_two_ff <= 1'b1;
         first_op_ff    <= 1'b1;
         tick_count_ff  <= '0;
         timeout_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         version_two_ff <= version_two_in;
         first_op_ff    <= first_op_in;
         tick_count_ff  <= tick_count_in;
         timeout_ff     <= timeout_in;
      end
   end

endmodule

// ===== rtl/core/sd_spi_init_sequencer.sv =====
// SD card SPI-mode start-up sequencer. A start transaction (mode 0) issues CMD0; each
// response transaction (mode 1) with R1 and the trailing bytes selects the next command
// (CMD8, CMD58, the CMD55/ACMD41 loop, a final CMD58) or ends the sequence with card kind
// or failure cause; tick transactions (mode 2) advance the ACMD41 timeout. Each request
// lands in an input register and is decided straight into the result register once the
// result slot is free or draining; a new transaction can be accepted as the last one is
// decided, so one transaction per cycle is sustained while rsp_ready stays high. Requests
// that yield no result still pass through the same single decision stage in order.
// depends on sdspi_pkg, sdspi_csr, sdspi_fsm and sd_spi_init_sequencer_macros.svh
`include "sd_spi_init_sequencer_macros.svh"

module sd_spi_init_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_r1,
   input  logic [31:0] req_tail,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_issue_command,
   output logic [7:0]  rsp_cmd_byte,
   output logic [31:0] rsp_argument,
   output logic [7:0]  rsp_crc_byte,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_card_kind,
   output logic [2:0]  rsp_fail_cause,
   // csr write port
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import sdspi_pkg::*;

   cfg_type      cfg;
   req_item_type item_ff;
   logic         item_valid_ff;
   rsp_item_type rsp_ff;
   rsp_item_type result;
   logic         rsp_valid_ff;
   logic         has_result;
   logic         advance;

   sdspi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdspi_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (item_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   // decide when the result slot is free or draining this cycle
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.mode <= req_mode;
         item_ff.r1   <= req_r1;
         item_ff.tail <= req_tail;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_issue_command = rsp_ff.issue_command;
   assign rsp_cmd_byte      = rsp_ff.cmd_byte;
   assign rsp_argument      = rsp_ff.argument;
   assign rsp_crc_byte      = rsp_ff.crc_byte;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_card_kind     = rsp_ff.card_kind;
   assign rsp_fail_cause    = rsp_ff.fail_cause;

   // checks
   `SDSPI_ASSERT_NOW(a_rsp_kind_exclusive, clock, reset, rsp_valid,
      rsp_issue_command != rsp_done_res, "result is neither command nor end")
   `SDSPI_ASSERT_NOW(a_cmd_no_status, clock, reset, rsp_valid && rsp_issue_command,
      rsp_card_kind == KIND_V1 && rsp_fail_cause == CAUSE_NONE, "command carries status")
   `SDSPI_ASSERT_NEXT(a_item_held, clock, reset, item_valid_ff && !advance,
      item_valid_ff && $stable(item_ff), "pending transaction lost")

endmodule
